// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the cluster chain walker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define FCW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define FCW_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `FCW_ASSERT(lbl, clk, rstn, !(cond), msg)

`else

`define FCW_ASSERT(lbl, clk, rstn, prop, msg)
`define FCW_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ----- sv/fcw_pkg.sv -----
// ----------------------------------------------------------------------------
// fcw_pkg
// Shared widths, defaults, request codes and control bundles of the walker.
// ----------------------------------------------------------------------------
package fcw_pkg;

  localparam int unsigned TableBytesDef = 8192;
  localparam int unsigned MaxChainDef   = 4096;

  localparam int unsigned IdW   = 12;
  localparam int unsigned AddrW = 13;
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 13;
  localparam int unsigned ReqW  = 2;

  localparam logic [IdW-1:0] EndMarkerRst = 12'h0FFF;

  typedef enum logic [ReqW-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_COUNT  = 2'd2
  } req_e;

  // Controller to datapath
  typedef struct packed {
    logic wr_en;
    logic load_cur;
    logic rd_en;
    logic step;
    logic out_load;
    logic out_is_count;
  } fcw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic at_end;
    logic at_limit;
  } fcw_stat_t;

endpackage

// ----- sv/fcw_ram.sv -----
// ----------------------------------------------------------------------------
// fcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/fcw_dp.sv -----
// ----------------------------------------------------------------------------
// fcw_dp
// Datapath: banked table store, entry unpacking, walk registers, result regs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcw_dp #(
  parameter int unsigned TABLE_BYTES = fcw_pkg::TableBytesDef,
  parameter int unsigned MAX_CHAIN   = fcw_pkg::MaxChainDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fcw_pkg::fcw_cmd_t           cmd_i,
  output fcw_pkg::fcw_stat_t          stat_o,
  input  logic [fcw_pkg::IdW-1:0]     cluster_id_i,
  input  logic [fcw_pkg::AddrW-1:0]   byte_addr_i,
  input  logic [fcw_pkg::ByteW-1:0]   byte_value_i,
  input  logic                        cfg_we_i,
  input  logic [fcw_pkg::IdW-1:0]     cfg_data_i,
  output logic [fcw_pkg::IdW-1:0]     next_cluster_o,
  output logic [fcw_pkg::LenW-1:0]    chain_length_o,
  output logic                        limit_hit_o
);

  localparam int unsigned AddrW     = fcw_pkg::AddrW;
  localparam int unsigned IdW       = fcw_pkg::IdW;
  localparam int unsigned LenW      = fcw_pkg::LenW;
  localparam int unsigned ByteW     = fcw_pkg::ByteW;
  localparam int unsigned BankDepth = (TABLE_BYTES + 1) / 2;
  localparam int unsigned BankAw    = $clog2(BankDepth);
  localparam logic [AddrW:0] TableEnd = (AddrW + 1)'(TABLE_BYTES);

  logic [IdW-1:0]   end_marker_q;
  logic [IdW-1:0]   cur_q;
  logic [LenW-1:0]  count_q;
  logic [AddrW-1:0] off;
  logic [AddrW-1:0] off1;
  logic             wr_ok;
  logic             we_even;
  logic             we_odd;
  logic [ByteW-1:0] even_rd;
  logic [ByteW-1:0] odd_rd;
  logic             par_q;
  logic             lo_ok_q;
  logic             hi_ok_q;
  logic [ByteW-1:0] lo_byte;
  logic [ByteW-1:0] hi_byte;
  logic [2*ByteW-1:0] pair;
  logic [IdW-1:0]   entry;
  logic [IdW-1:0]   next_cluster_q;
  logic [LenW-1:0]  chain_length_q;
  logic             limit_hit_q;

  // Byte pair of an entry starts at id + id/2; the two bytes sit in
  // opposite banks, so both come out of one read.
  assign off  = AddrW'(cur_q) + AddrW'(cur_q >> 1);
  assign off1 = off + AddrW'(1);

  assign wr_ok   = {1'b0, byte_addr_i} < TableEnd;
  assign we_even = cmd_i.wr_en && wr_ok && !byte_addr_i[0];
  assign we_odd  = cmd_i.wr_en && wr_ok && byte_addr_i[0];

  fcw_ram #(
    .WIDTH (ByteW),
    .DEPTH (BankDepth)
  ) u_even_bank (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (byte_addr_i[BankAw:1]),
    .wdata_i (byte_value_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (off1[BankAw:1]),
    .rdata_o (even_rd)
  );

  fcw_ram #(
    .WIDTH (ByteW),
    .DEPTH (BankDepth)
  ) u_odd_bank (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (byte_addr_i[BankAw:1]),
    .wdata_i (byte_value_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (off[BankAw:1]),
    .rdata_o (odd_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      par_q   <= off[0];
      lo_ok_q <= {1'b0, off} < TableEnd;
      hi_ok_q <= {1'b0, off1} < TableEnd;
    end
  end

  // Bytes past the table end read as zero
  assign lo_byte = !lo_ok_q ? '0 : (par_q ? odd_rd : even_rd);
  assign hi_byte = !hi_ok_q ? '0 : (par_q ? even_rd : odd_rd);
  assign pair    = {hi_byte, lo_byte};
  assign entry   = cur_q[0] ? pair[2*ByteW-1:4] : pair[IdW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_marker_q <= fcw_pkg::EndMarkerRst;
    end else if (cfg_we_i) begin
      end_marker_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cur) begin
      cur_q   <= cluster_id_i;
      count_q <= '0;
    end else if (cmd_i.step) begin
      cur_q   <= entry;
      count_q <= count_q + LenW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_is_count) begin
        next_cluster_q <= '0;
        chain_length_q <= count_q;
        limit_hit_q    <= !stat_o.at_end;
      end else begin
        next_cluster_q <= cur_q;
        chain_length_q <= '0;
        limit_hit_q    <= 1'b0;
      end
    end
  end

  assign stat_o.at_end   = (cur_q == end_marker_q);
  assign stat_o.at_limit = (count_q == LenW'(MAX_CHAIN));

  assign next_cluster_o = next_cluster_q;
  assign chain_length_o = chain_length_q;
  assign limit_hit_o    = limit_hit_q;

  `FCW_ASSERT_NEVER(a_step_past_limit, clk_i, rst_ni, cmd_i.step && stat_o.at_limit, "walk stepped past the chain limit")
  `FCW_ASSERT(a_limit_len, clk_i, rst_ni, (cmd_i.out_load && cmd_i.out_is_count && !stat_o.at_end) |=> (limit_hit_o && chain_length_o == LenW'(MAX_CHAIN)), "limit result without saturated length")
  `FCW_ASSERT(a_cfg_write, clk_i, rst_ni, cfg_we_i |=> (end_marker_q == $past(cfg_data_i)), "end marker write lost")

endmodule

// ----- sv/fcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// fcw_ctrl
// Controller: input handshake, walk sequencing and output register control.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcw_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fcw_pkg::ReqW-1:0]      req_type_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fcw_pkg::fcw_cmd_t             cmd_o,
  input  fcw_pkg::fcw_stat_t            stat_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LK_RD,
    ST_LK_LATCH,
    ST_CHECK,
    ST_CNT_LATCH,
    ST_FIN
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   is_count_q;
  logic   is_count_d;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   accept;
  logic   out_free;
  logic   walk_done;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign walk_done = stat_i.at_end || stat_i.at_limit;

  always_comb begin
    state_d      = state_q;
    is_count_d   = is_count_q;
    out_valid_d  = out_valid_q && out_stall_i;
    cmd_o        = '0;
    cmd_o.out_is_count = is_count_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (fcw_pkg::req_e'(req_type_i))
            fcw_pkg::REQ_LOAD: begin
              cmd_o.wr_en = 1'b1;
            end
            fcw_pkg::REQ_LOOKUP: begin
              cmd_o.load_cur = 1'b1;
              is_count_d     = 1'b0;
              state_d        = ST_LK_RD;
            end
            fcw_pkg::REQ_COUNT: begin
              cmd_o.load_cur = 1'b1;
              is_count_d     = 1'b1;
              state_d        = ST_CHECK;
            end
            default: begin
              // reserved request: drop it
            end
          endcase
        end
      end
      ST_LK_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_LK_LATCH;
      end
      ST_LK_LATCH: begin
        cmd_o.step = 1'b1;
        state_d    = ST_FIN;
      end
      ST_CHECK: begin
        // end marker wins over the limit
        if (walk_done) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_CNT_LATCH;
        end
      end
      ST_CNT_LATCH: begin
        cmd_o.step = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_FIN: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      is_count_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      is_count_q  <= is_count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  `FCW_ASSERT(a_load_free, clk_i, rst_ni, cmd_o.out_load |-> !(out_valid_q && out_stall_i), "result overwrote a pending item")
  `FCW_ASSERT(a_rd_then_step, clk_i, rst_ni, cmd_o.rd_en |=> cmd_o.step, "table read not followed by entry latch")
  `FCW_ASSERT(a_valid_source, clk_i, rst_ni, $rose(out_valid_q) |-> $past(cmd_o.out_load), "output valid without a result load")

endmodule

// ----- sv/fat12_cluster_chain_walker_top.sv -----
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_top
// FAT12 allocation table store with entry lookup and chain length counting.
// ----------------------------------------------------------------------------
// The table lives in two byte-wide RAM banks (even and odd addresses), so
// the two bytes of a 12-bit entry come out of a single registered read.
// A load item writes one byte and is taken every cycle, back to back; loads
// at or past TABLE_BYTES are dropped. A lookup item reads both banks,
// latches the entry and then loads it into the output register. A count
// item walks the chain, each step being one bank read and one entry
// latch, and stops at MAX_CHAIN with limit_hit set. One lookup or
// count is in flight at a time; while it runs the input is stalled, and a
// finished result waits in the output register. The table is not cleared
// at reset: a byte must be loaded before any entry that covers it is read.
// end_marker may be written at any idle time and resets to 0xFFF.
module fat12_cluster_chain_walker_top #(
  parameter int unsigned TABLE_BYTES = fcw_pkg::TableBytesDef,
  parameter int unsigned MAX_CHAIN   = fcw_pkg::MaxChainDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [fcw_pkg::ReqW-1:0]    req_type_i,
  input  logic [fcw_pkg::IdW-1:0]     cluster_id_i,
  input  logic [fcw_pkg::AddrW-1:0]   byte_addr_i,
  input  logic [fcw_pkg::ByteW-1:0]   byte_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [fcw_pkg::IdW-1:0]     next_cluster_o,
  output logic [fcw_pkg::LenW-1:0]    chain_length_o,
  output logic                        limit_hit_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fcw_pkg::IdW-1:0]     cfg_data_i
);

  fcw_pkg::fcw_cmd_t  cmd;
  fcw_pkg::fcw_stat_t stat;

  assign cfg_ready_o = 1'b1;

  fcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  fcw_dp #(
    .TABLE_BYTES (TABLE_BYTES),
    .MAX_CHAIN   (MAX_CHAIN)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cluster_id_i   (cluster_id_i),
    .byte_addr_i    (byte_addr_i),
    .byte_value_i   (byte_value_i),
    .cfg_we_i       (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .next_cluster_o (next_cluster_o),
    .chain_length_o (chain_length_o),
    .limit_hit_o    (limit_hit_o)
  );

endmodule

// ----- sim/fat12_cluster_chain_walker_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_top_tb
// Loads FAT12 table bytes, builds open and cyclic cluster chains with random
// content, and checks every entry lookup and chain count against a local
// model of the table. Input bursts and output stalls vary at random.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker_top_tb;

  localparam int unsigned TableBytes = fcw_pkg::TableBytesDef;
  localparam int unsigned MaxChain   = fcw_pkg::MaxChainDef;
  localparam int unsigned IdW        = fcw_pkg::IdW;
  localparam int unsigned AddrW      = fcw_pkg::AddrW;
  localparam int unsigned ByteW      = fcw_pkg::ByteW;
  localparam int unsigned LenW       = fcw_pkg::LenW;
  localparam int unsigned ReqW       = fcw_pkg::ReqW;
  localparam int unsigned MaxIds     = 48;
  localparam int unsigned WalkCap    = 256;
  localparam int unsigned DrainCyc   = 16;
  localparam logic [ReqW-1:0] REQ_RSVD = 2'd3;

  typedef struct packed {
    logic [ReqW-1:0]  kind;
    logic [IdW-1:0]   id;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] val;
  } fat_req_t;

  typedef struct packed {
    logic [IdW-1:0]  next;
    logic [LenW-1:0] len;
    logic            hit;
  } fat_res_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [ReqW-1:0]  req_type_i = '0;
  logic [IdW-1:0]   cluster_id_i = '0;
  logic [AddrW-1:0] byte_addr_i = '0;
  logic [ByteW-1:0] byte_value_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [IdW-1:0]   next_cluster_o;
  logic [LenW-1:0]  chain_length_o;
  logic             limit_hit_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [IdW-1:0]   cfg_data_i = '0;

  fat12_cluster_chain_walker_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .cluster_id_i  (cluster_id_i),
    .byte_addr_i   (byte_addr_i),
    .byte_value_i  (byte_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .next_cluster_o(next_cluster_o),
    .chain_length_o(chain_length_o),
    .limit_hit_o   (limit_hit_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Table model updated as items are accepted
  logic [ByteW-1:0] fat_tbl [TableBytes];
  logic [IdW-1:0]   end_mark_q = fcw_pkg::EndMarkerRst;
  fat_res_t         fat_result_q [$];

  // Table as the stimulus plan will leave it, ahead of the block
  logic [ByteW-1:0] plan_tbl [TableBytes];
  bit               plan_wr [TableBytes];
  logic [IdW-1:0]   plan_mark = fcw_pkg::EndMarkerRst;
  logic [IdW-1:0]   chain_ids [MaxIds];
  int               limit_budget = 10;
  int               gen_count = 0;

  fat_req_t         fat_req_q [$];
  fat_req_t         drv_item;
  int               burst_left;
  int               gap_left;
  logic [15:0]      stall_pat;
  int               stall_hold;
  fat_res_t         want;
  int               err_cnt = 0;

  function automatic logic [ByteW-1:0] fat_byte(int unsigned a);
    return (a < TableBytes) ? fat_tbl[a] : '0;
  endfunction

  function automatic logic [IdW-1:0] fat_entry(logic [IdW-1:0] id);
    int unsigned off;
    logic [15:0] pair;
    off = id + (id >> 1);
    pair = {fat_byte(off + 1), fat_byte(off)};
    return id[0] ? pair[15:4] : pair[11:0];
  endfunction

  function automatic void fat_apply(fat_req_t r);
    fat_res_t res;
    logic [IdW-1:0] cur;
    int unsigned n;
    res = '0;
    case (r.kind)
      fcw_pkg::REQ_LOAD: if (r.addr < TableBytes) fat_tbl[r.addr] = r.val;
      fcw_pkg::REQ_LOOKUP: begin
        res.next = fat_entry(r.id);
        fat_result_q.push_back(res);
      end
      fcw_pkg::REQ_COUNT: begin
        cur = r.id;
        n = 0;
        while (cur != end_mark_q) begin
          if (n >= MaxChain) begin
            res.hit = 1'b1;
            break;
          end
          n++;
          cur = fat_entry(cur);
        end
        res.len = n[LenW-1:0];
        fat_result_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // ---- stimulus planning ----

  function automatic logic [IdW-1:0] plan_entry(logic [IdW-1:0] id);
    int unsigned off;
    logic [15:0] pair;
    off = id + (id >> 1);
    pair = {plan_tbl[off + 1], plan_tbl[off]};
    return id[0] ? pair[15:4] : pair[11:0];
  endfunction

  task automatic push_item(logic [ReqW-1:0] kind, logic [IdW-1:0] id,
                           logic [AddrW-1:0] addr, logic [ByteW-1:0] val);
    fat_req_t r;
    r.kind = kind;
    r.id = id;
    r.addr = addr;
    r.val = val;
    if (kind == fcw_pkg::REQ_LOAD) begin
      plan_tbl[addr] = val;
      plan_wr[addr] = 1'b1;
    end
    if (kind != REQ_RSVD) gen_count++;
    fat_req_q.push_back(r);
  endtask

  // Rewrite one 12-bit entry, keeping the neighbor nibble of a shared byte
  task automatic set_entry(logic [IdW-1:0] id, logic [IdW-1:0] v);
    int unsigned off;
    logic [15:0] pair;
    off = id + (id >> 1);
    pair[15:8] = plan_wr[off + 1] ? plan_tbl[off + 1] : 8'($urandom);
    pair[7:0]  = plan_wr[off] ? plan_tbl[off] : 8'($urandom);
    if (id[0]) pair[15:4] = v;
    else pair[11:0] = v;
    push_item(fcw_pkg::REQ_LOAD, 12'($urandom), 13'(off), pair[7:0]);
    push_item(fcw_pkg::REQ_LOAD, 12'($urandom), 13'(off + 1), pair[15:8]);
  endtask

  // Fill unwritten bytes under an entry so a lookup never reads undefined data
  task automatic ensure_entry(logic [IdW-1:0] id);
    int unsigned off;
    off = id + (id >> 1);
    for (int unsigned a = off; a <= off + 1; a++)
      if (!plan_wr[a]) push_item(fcw_pkg::REQ_LOAD, 12'($urandom), 13'(a), 8'($urandom));
  endtask

  // Issue a count only if its walk touches written bytes and stays affordable
  task automatic try_count(logic [IdW-1:0] start);
    logic [IdW-1:0] cur;
    int unsigned steps;
    int unsigned off;
    cur = start;
    steps = 0;
    while (cur != plan_mark && steps < MaxChain) begin
      off = cur + (cur >> 1);
      if (!plan_wr[off] || !plan_wr[off + 1]) return;
      steps++;
      cur = plan_entry(cur);
    end
    if (steps >= MaxChain) begin
      if (limit_budget == 0) return;
      limit_budget--;
    end else if (steps > WalkCap) begin
      return;
    end
    push_item(fcw_pkg::REQ_COUNT, start, 13'($urandom), 8'($urandom));
  endtask

  task automatic build_chain(int len, bit closed);
    logic [IdW-1:0] c;
    bit dup;
    int k;
    for (int i = 0; i < len; i++) begin
      do begin
        c = 12'($urandom);
        dup = (c == plan_mark);
        for (int j = 0; j < i; j++) if (chain_ids[j] == c) dup = 1'b1;
      end while (dup);
      chain_ids[i] = c;
    end
    for (int i = 0; i < len - 1; i++) set_entry(chain_ids[i], chain_ids[i + 1]);
    set_entry(chain_ids[len - 1], closed ? chain_ids[0] : plan_mark);
    try_count(chain_ids[0]);
    if (closed) return;
    for (int i = $urandom_range(0, 2); i > 0; i--)
      push_item(fcw_pkg::REQ_LOOKUP, chain_ids[$urandom_range(0, len - 1)],
                13'($urandom), 8'($urandom));
    if ($urandom_range(0, 2) == 0) try_count(chain_ids[$urandom_range(0, len - 1)]);
    // Break one link and walk again
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, len - 1);
      set_entry(chain_ids[k], 12'($urandom));
      try_count(chain_ids[0]);
    end
  endtask

  task automatic random_scenario();
    int r;
    logic [IdW-1:0] id;
    r = $urandom_range(0, 99);
    if (r < 55 || (r < 60 && limit_budget == 0)) begin
      build_chain(($urandom_range(0, 7) == 0) ? $urandom_range(13, MaxIds)
                                              : $urandom_range(1, 12), 1'b0);
    end else if (r < 60) begin
      build_chain($urandom_range(1, 6), 1'b1);
    end else if (r < 75) begin
      id = 12'($urandom);
      ensure_entry(id);
      push_item(fcw_pkg::REQ_LOOKUP, id, 13'($urandom), 8'($urandom));
    end else if (r < 85) begin
      push_item(fcw_pkg::REQ_LOAD, 12'($urandom), 13'($urandom), 8'($urandom));
    end else if (r < 90) begin
      push_item(fcw_pkg::REQ_COUNT, plan_mark, 13'($urandom), 8'($urandom));
    end else if (r < 95) begin
      push_item(REQ_RSVD, 12'($urandom), 13'($urandom), 8'($urandom));
    end else begin
      try_count(12'($urandom));
    end
  endtask

  // Sample at the falling edge, after the driver has settled
  task automatic wait_idle();
    while (fat_req_q.size() != 0 || in_valid_i || fat_result_q.size() != 0)
      @(negedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
  endtask

  task automatic write_marker(logic [IdW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    end_mark_q = v;
    plan_mark = v;
  endtask

  // ---- input driver ----
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      req_type_i   <= '0;
      cluster_id_i <= '0;
      byte_addr_i  <= '0;
      byte_value_i <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) fat_apply(drv_item);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (fat_req_q.size() != 0) begin
          drv_item = fat_req_q.pop_front();
          in_valid_i   <= 1'b1;
          req_type_i   <= drv_item.kind;
          cluster_id_i <= drv_item.id;
          byte_addr_i  <= drv_item.addr;
          byte_value_i <= drv_item.val;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 4) == 0) ? 96 : $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---- result monitor and output stall pattern ----
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_pat = '0;
      stall_hold = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (fat_result_q.size() == 0) begin
          $error("unexpected result: next_cluster %0d chain_length %0d limit_hit %0d",
                 next_cluster_o, chain_length_o, limit_hit_o);
          err_cnt++;
        end else begin
          want = fat_result_q.pop_front();
          if (next_cluster_o !== want.next) begin
            $error("next_cluster: expected %0d, got %0d", want.next, next_cluster_o);
            err_cnt++;
          end
          if (chain_length_o !== want.len) begin
            $error("chain_length: expected %0d, got %0d", want.len, chain_length_o);
            err_cnt++;
          end
          if (limit_hit_o !== want.hit) begin
            $error("limit_hit: expected %0d, got %0d", want.hit, limit_hit_o);
            err_cnt++;
          end
        end
      end
      // Rotate a random pattern; keep one bit clear so stalls stay bounded
      if (stall_hold == 0) begin
        stall_hold = $urandom_range(32, 96);
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'h0000 : (16'($urandom) & 16'h7FFF);
      end
      stall_hold--;
      out_stall_i <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  // ---- test sequence ----
  initial begin
    int target;
    logic [IdW-1:0] m;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Byte extremes, even, odd and top entries, an end-at-start walk, a cycle
    push_item(fcw_pkg::REQ_LOAD, 12'hFFF, 13'd0, 8'h00);
    push_item(fcw_pkg::REQ_LOAD, 12'h000, 13'h1FFF, 8'hFF);
    set_entry(12'd0, 12'd3);
    set_entry(12'd3, 12'hFFF);
    set_entry(12'hFFF, 12'd0);
    push_item(fcw_pkg::REQ_LOOKUP, 12'd0, 13'h1FFF, 8'hFF);
    push_item(fcw_pkg::REQ_LOOKUP, 12'd3, 13'd0, 8'h00);
    push_item(fcw_pkg::REQ_LOOKUP, 12'hFFF, 13'h0AAA, 8'h55);
    push_item(fcw_pkg::REQ_COUNT, 12'hFFF, 13'h1555, 8'hAA);
    push_item(fcw_pkg::REQ_COUNT, plan_mark == 12'hFFF ? 12'hFFF : plan_mark, 13'd0, 8'h00);
    push_item(REQ_RSVD, 12'hABC, 13'h1234, 8'h5A);
    set_entry(12'd5, 12'd6);
    set_entry(12'd6, 12'd5);
    push_item(fcw_pkg::REQ_COUNT, 12'd5, 13'h1FFF, 8'hFF);
    wait_idle();

    for (int p = 1; p <= 4; p++) begin
      case (p)
        1: m = 12'h000;
        3: m = 12'hFFF;
        default: m = 12'($urandom);
      endcase
      write_marker(m);
      target = gen_count + 150;
      while (gen_count < target) random_scenario();
      wait_idle();
    end

    if (err_cnt == 0 && fat_result_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #18_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
